FILE: src/bsss_pkg.sv
package bsss_pkg;

  // Store geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int TAG_BITS    = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field and register widths
  localparam int SECTOR_W  = 32;
  localparam int TAG_OUT_W = 8;
  localparam int TAG_W     = (TAG_BITS < TAG_OUT_W) ? TAG_BITS : TAG_OUT_W;
  localparam int REG_W     = 7;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [REG_W-1:0] LIMIT_RESET  = 7'd10;
  localparam logic [REG_W-1:0] PERIOD_RESET = 7'd100;

  // Register indexes (paddr[2])
  localparam logic REG_QUEUE_LIMIT = 1'b0;
  localparam logic REG_TICK_PERIOD = 1'b1;

  // Input transaction modes
  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_DRAIN = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic [SECTOR_W-1:0] sector;
    logic [7:0]          request_tag;
  } in_item_t;

  typedef struct packed {
    logic [SECTOR_W-1:0]  out_sector;
    logic [TAG_OUT_W-1:0] out_tag;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [CNT_W-1:0] limit;
    logic [REG_W-1:0] period;
  } cfg_t;

endpackage

FILE: src/bsss_store.sv
module bsss_store
  import bsss_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/bsss_cfg.sv
module bsss_cfg
  import bsss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [REG_W-1:0] limit_r;
  logic [REG_W-1:0] period_r;
  logic             reg_sel;
  logic             wr_fire;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_fire = psel && penable && pwrite;

  // Register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RESET;
      period_r <= PERIOD_RESET;
    end else if (wr_fire) begin
      unique case (reg_sel)
        REG_QUEUE_LIMIT: limit_r  <= pwdata[REG_W-1:0];
        REG_TICK_PERIOD: period_r <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_QUEUE_LIMIT: prdata = CFG_DATA_W'(limit_r);
      REG_TICK_PERIOD: prdata = CFG_DATA_W'(period_r);
      default:         prdata = '0;
    endcase
  end

  // Clamp limit to 1..depth and period to at least 1
  always_comb begin
    if (limit_r == '0) begin
      cfg.limit = CNT_W'(1);
    end else if (limit_r > REG_W'(QUEUE_DEPTH)) begin
      cfg.limit = CNT_W'(QUEUE_DEPTH);
    end else begin
      cfg.limit = CNT_W'(limit_r);
    end
    cfg.period = (period_r == '0) ? REG_W'(1) : period_r;
  end

endmodule

FILE: src/bsss_seq.sv
module bsss_seq
  import bsss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  input  cfg_t      cfg,
  input  entry_t    rd_data,
  output mem_req_t  mem_req,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_DSTART,
    S_DRAIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [REG_W-1:0] tick_r, tick_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  entry_t           new_r, new_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [CNT_W-1:0] cnt_inc;
  logic [REG_W-1:0] tick_inc;
  logic             is_last;
  entry_t           in_entry;

  assign cnt_inc  = count_r + 1'b1;
  assign tick_inc = tick_r + 1'b1;
  assign is_last  = (CNT_W'(idx_r) == (count_r - 1'b1));
  assign in_entry = '{sector: in_data.sector, tag: in_data.request_tag[TAG_W-1:0]};

  // Sequencer: insert in sorted order on add, stream out on dispatch
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    tick_nxt      = tick_r;
    idx_nxt       = idx_r;
    new_nxt       = new_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    mem_req       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_data.mode)
            MODE_ADD: begin
              new_nxt = in_entry;
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                state_nxt = S_DSTART;
              end else if (count_r == '0) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = '0;
                mem_req.wr_data = in_entry;
                count_nxt       = CNT_W'(1);
                if (CNT_W'(1) >= cfg.limit) begin
                  state_nxt = S_DSTART;
                end
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = IDX_W'(count_r - 1'b1);
                idx_nxt         = IDX_W'(count_r - 1'b1);
                state_nxt       = S_INS;
              end
            end
            MODE_TICK: begin
              if (tick_inc >= cfg.period) begin
                tick_nxt = '0;
                if (count_r != '0) begin
                  state_nxt = S_DSTART;
                end
              end else begin
                tick_nxt = tick_inc;
              end
            end
            MODE_DRAIN: begin
              if (count_r != '0) begin
                state_nxt = S_DSTART;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        // Shift larger entries up one slot, stop after the first not larger
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = idx_r + 1'b1;
        if (rd_data.sector > new_r.sector) begin
          mem_req.wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = S_INS_LAST;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_r - 1'b1;
            idx_nxt         = idx_r - 1'b1;
          end
        end else begin
          mem_req.wr_data = new_r;
          count_nxt       = cnt_inc;
          state_nxt       = (cnt_inc >= cfg.limit) ? S_DSTART : S_IDLE;
        end
      end
      S_INS_LAST: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = '0;
        mem_req.wr_data = new_r;
        count_nxt       = cnt_inc;
        state_nxt       = (cnt_inc >= cfg.limit) ? S_DSTART : S_IDLE;
      end
      S_DSTART: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = '0;
        idx_nxt         = '0;
        state_nxt       = S_DRAIN;
      end
      S_DRAIN: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.out_sector = rd_data.sector;
        out_data_nxt.out_tag    = TAG_OUT_W'(rd_data.tag);
        out_data_nxt.last       = is_last;
        if (is_last) begin
          count_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx_r + 1'b1;
          idx_nxt         = idx_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      new_r       <= new_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result only follows a dispatch cycle
  a_out_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_DRAIN))
    else $error("result strobe without dispatch");

  // The last result of a burst leaves the store empty
  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last) |-> (count_r == '0))
    else $error("store not empty after last result");

  // Fill level stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("store count overflow");

  // Drain on an empty store produces nothing
  a_empty_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.mode == MODE_DRAIN && count_r == '0) |=> (state_r == S_IDLE))
    else $error("dispatch on empty store");

  // Insertion only runs with something already stored
  a_ins_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |-> (count_r != '0))
    else $error("insert walk on empty store");

endmodule

FILE: src/batch_sector_sort_scheduler_unit.sv
// Batch sector-sort scheduler.
// Input channel: a transaction is taken when start is high and busy is low.
// in_data.mode selects add (store sector and tag), tick (advance the timer)
// or drain (dispatch everything now); mode three is ignored.
// The store is kept sorted by sector at all times: an add walks down from
// the top entry through one shared sector comparator, moving one larger entry
// up per cycle; an add into an empty store is written directly, any other add
// reads the top entry first, then walks past each entry with a larger sector.
// Ticks and drains leave busy low unless they start a dispatch.
// A dispatch (store reaches queue_limit on an add, or timer expiry or drain with
// a non-empty store) reads the store in order through its single read
// port: S_DSTART reads the first entry, S_DRAIN registers it, then one result
// per cycle on out_valid/out_data, last marking the final one. busy stays high
// until the final result is registered. Equal sectors leave in arrival order.
// Results are strobed for one cycle; the receiver cannot stall them.
// Configuration (queue_limit at 0x0, tick_period at 0x4) is written over the
// APB port while busy is low (a user rule, unenforced). Reset clears the count
// and timer, loads queue_limit 10 and tick_period 100; no clearing pass needed.
module batch_sector_sort_scheduler_unit
  import bsss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg;
  mem_req_t mem_req;
  entry_t   rd_data;

  bsss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bsss_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  bsss_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cfg       (cfg),
    .rd_data   (rd_data),
    .mem_req   (mem_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
